// ----- design/sawlc_pkg.sv -----
`timescale 1ns / 1ps

package sawlc_pkg;

    // input item kinds (s_tuser)
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_POLL  = 2'd2;

    // result kinds (m_tuser)
    localparam logic [1:0] RES_VERDICT = 2'd0;
    localparam logic [1:0] RES_SEND    = 2'd1;
    localparam logic [1:0] RES_FRAME   = 2'd2;

    // status codes
    localparam logic [2:0] ST_NO_PROGRESS = 3'd0;
    localparam logic [2:0] ST_PROGRESS    = 3'd1;
    localparam logic [2:0] ST_SHORT       = 3'd2;
    localparam logic [2:0] ST_MAC_REFUSED = 3'd3;
    localparam logic [2:0] ST_FORGED      = 3'd4;
    localparam logic [2:0] ST_QUEUED      = 3'd5;
    localparam logic [2:0] ST_FULL        = 3'd6;

    // frame type byte
    localparam logic [7:0] TYPE_DATA = 8'd0;
    localparam logic [7:0] TYPE_ACK  = 8'd1;

    // configuration register indexes
    localparam logic REG_LINK_KEYED = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    localparam logic [15:0] HDR_LEN     = 16'd6;
    localparam logic [15:0] MAC_LEN     = 16'd16;
    localparam logic [15:0] TIMEOUT_RST = 16'd500;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  status;
        logic        deliver;
        logic        out_is_ack;
        logic [31:0] out_seq;
        logic        out_authenticated;
        logic [15:0] out_message_tag;
        logic        last;
        logic        link_idle;
    } result_t;

endpackage

// ----- design/stop_and_wait_link_control_unit.sv -----
`timescale 1ns / 1ps

// Stop-and-wait ARQ link controller with MAC gating.
// Input channel s_*: one transaction is a received frame header, a send request
// or a poll tick, selected by s_tuser. Output channel m_*: verdicts and outgoing
// frames, m_tuser gives the result kind, m_tlast marks the final result of an
// input transaction. Registers are written through cfg_we/cfg_index/cfg_data.
// An item is evaluated in the cycle it is accepted; its results are registered
// into the result buffer and appear on m_* once earlier results are taken. A
// four-entry result buffer decouples the two sides: an item with one result can
// be accepted every cycle while the receiver takes results, a poll that yields
// an ack and a data frame puts two results in, so the sustained rate is bounded
// by the single output port of the result buffer. Send requests go into a queue
// memory with registered read; the entry at the queue head is prefetched (with
// write bypass) so a poll can pop it in the cycle it is accepted.
// Reset clears all link state, sets link_keyed to 0 and the timeout to 500 ms;
// the queue memory holds no valid data until written. When the receiver stalls
// the results wait in the buffer; s_tready drops once fewer than two buffer
// entries are free.
module stop_and_wait_link_control_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_length, auth_marked, mac_matches, frame_type, frame_seq,
    // message_tag, now_ms, zero fill
    input  logic [sawlc_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, deliver, out_is_ack, out_seq, out_authenticated,
    // out_message_tag, link_idle, zero fill
    output logic [sawlc_pkg::OUT_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [15:0]                      cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RF_DEPTH = 4;
    localparam int RF_AW = 2;

    // input fields
    logic [15:0] frame_length;
    logic        auth_marked;
    logic        mac_matches;
    logic [7:0]  frame_type;
    logic [31:0] frame_seq;
    logic [15:0] message_tag;
    logic [63:0] now_ms;

    assign frame_length = s_tdata[15:0];
    assign auth_marked  = s_tdata[16];
    assign mac_matches  = s_tdata[17];
    assign frame_type   = s_tdata[25:18];
    assign frame_seq    = s_tdata[57:26];
    assign message_tag  = s_tdata[73:58];
    assign now_ms       = s_tdata[137:74];

    // configuration
    logic        link_keyed_reg;
    logic [15:0] timeout_reg;

    // link state
    logic [31:0] expected_recv_seq_reg, expected_recv_seq_next;
    logic [31:0] next_send_seq_reg, next_send_seq_next;
    logic        ack_owed_reg, ack_owed_next;
    logic [31:0] ack_number_reg, ack_number_next;
    logic        awaiting_ack_reg, awaiting_ack_next;
    logic [15:0] pending_tag_reg, pending_tag_next;
    logic        pending_auth_reg, pending_auth_next;
    logic [63:0] last_send_time_reg, last_send_time_next;
    logic [AW-1:0] queue_head_reg, queue_head_next;
    logic [AW-1:0] queue_tail_reg, queue_tail_next;
    logic [CW-1:0] queue_count_reg, queue_count_next;

    // queue memory: {keyed, tag}
    logic [16:0] queue_mem [QUEUE_DEPTH];
    logic [16:0] head_data_reg;
    logic        q_we;
    logic [16:0] q_wdata;

    // result buffer
    sawlc_pkg::result_t rf_mem [RF_DEPTH];
    logic [RF_AW-1:0] rf_wr_reg, rf_wr_next;
    logic [RF_AW-1:0] rf_rd_reg, rf_rd_next;
    logic [RF_AW:0]   rf_cnt_reg, rf_cnt_next;
    sawlc_pkg::result_t res0, res1;
    logic [1:0] n_res;

    logic accept;
    logic pop_out;
    logic [63:0] elapsed;
    logic        adv;
    logic        clears;
    logic        sent;

    assign s_tready = (rf_cnt_reg <= (RF_AW+1)'(RF_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (rf_cnt_reg != '0);
    assign pop_out  = m_tvalid && m_tready;
    assign elapsed  = now_ms - last_send_time_reg;

    always_comb
    begin
        expected_recv_seq_next = expected_recv_seq_reg;
        next_send_seq_next     = next_send_seq_reg;
        ack_owed_next          = ack_owed_reg;
        ack_number_next        = ack_number_reg;
        awaiting_ack_next      = awaiting_ack_reg;
        pending_tag_next       = pending_tag_reg;
        pending_auth_next      = pending_auth_reg;
        last_send_time_next    = last_send_time_reg;
        queue_head_next        = queue_head_reg;
        queue_tail_next        = queue_tail_reg;
        queue_count_next       = queue_count_reg;
        q_we    = 1'b0;
        q_wdata = {link_keyed_reg, message_tag};
        res0    = '0;
        res1    = '0;
        n_res   = 2'd0;
        adv     = (frame_seq == expected_recv_seq_reg);
        clears  = awaiting_ack_reg && (frame_seq == next_send_seq_reg);
        sent    = 1'b0;

        if (accept)
        begin
            case (s_tuser)
                sawlc_pkg::KIND_FRAME:
                begin
                    n_res = 2'd1;
                    res0.result_kind = sawlc_pkg::RES_VERDICT;
                    if (frame_length < sawlc_pkg::HDR_LEN)
                        res0.status = sawlc_pkg::ST_SHORT;
                    else if (auth_marked && !link_keyed_reg)
                        res0.status = sawlc_pkg::ST_MAC_REFUSED;
                    else if (auth_marked &&
                             frame_length < sawlc_pkg::HDR_LEN + sawlc_pkg::MAC_LEN)
                        res0.status = sawlc_pkg::ST_SHORT;
                    else if (auth_marked && !mac_matches)
                        res0.status = sawlc_pkg::ST_MAC_REFUSED;
                    else if (frame_type == sawlc_pkg::TYPE_DATA)
                    begin
                        if (link_keyed_reg && !auth_marked && adv)
                            res0.status = sawlc_pkg::ST_FORGED;
                        else
                        begin
                            ack_owed_next = 1'b1;
                            if (adv)
                            begin
                                expected_recv_seq_next = expected_recv_seq_reg + 32'd1;
                                ack_number_next        = expected_recv_seq_reg;
                                res0.deliver           = 1'b1;
                                res0.status            = sawlc_pkg::ST_PROGRESS;
                            end
                            else
                            begin
                                ack_number_next = expected_recv_seq_reg - 32'd1;
                                res0.status     = sawlc_pkg::ST_NO_PROGRESS;
                            end
                        end
                    end
                    else if (frame_type == sawlc_pkg::TYPE_ACK)
                    begin
                        if (link_keyed_reg && !auth_marked && clears)
                            res0.status = sawlc_pkg::ST_FORGED;
                        else if (clears)
                        begin
                            awaiting_ack_next  = 1'b0;
                            next_send_seq_next = next_send_seq_reg + 32'd1;
                            res0.status        = sawlc_pkg::ST_PROGRESS;
                        end
                        else
                            res0.status = sawlc_pkg::ST_NO_PROGRESS;
                    end
                    else
                        res0.status = sawlc_pkg::ST_NO_PROGRESS;
                end
                sawlc_pkg::KIND_SEND:
                begin
                    n_res = 2'd1;
                    res0.result_kind = sawlc_pkg::RES_SEND;
                    if (queue_count_reg == CW'(QUEUE_DEPTH))
                        res0.status = sawlc_pkg::ST_FULL;
                    else
                    begin
                        q_we             = 1'b1;
                        queue_tail_next  = (queue_tail_reg == AW'(QUEUE_DEPTH - 1)) ?
                                           '0 : queue_tail_reg + 1'b1;
                        queue_count_next = queue_count_reg + 1'b1;
                        res0.status      = sawlc_pkg::ST_QUEUED;
                    end
                end
                sawlc_pkg::KIND_POLL:
                begin
                    if (ack_owed_reg)
                    begin
                        res0.result_kind       = sawlc_pkg::RES_FRAME;
                        res0.out_is_ack        = 1'b1;
                        res0.out_seq           = ack_number_reg;
                        res0.out_authenticated = link_keyed_reg;
                        ack_owed_next          = 1'b0;
                    end
                    if (!awaiting_ack_reg && queue_count_reg != '0)
                    begin
                        sent                = 1'b1;
                        queue_head_next     = (queue_head_reg == AW'(QUEUE_DEPTH - 1)) ?
                                              '0 : queue_head_reg + 1'b1;
                        queue_count_next    = queue_count_reg - 1'b1;
                        pending_tag_next    = head_data_reg[15:0];
                        pending_auth_next   = head_data_reg[16];
                        awaiting_ack_next   = 1'b1;
                        last_send_time_next = now_ms;
                    end
                    else if (awaiting_ack_reg && elapsed >= {48'd0, timeout_reg})
                    begin
                        sent                = 1'b1;
                        last_send_time_next = now_ms;
                    end
                    if (sent)
                    begin
                        res1                   = '0;
                        res1.result_kind       = sawlc_pkg::RES_FRAME;
                        res1.out_seq           = next_send_seq_reg;
                        res1.out_authenticated = pending_auth_next;
                        res1.out_message_tag   = pending_tag_next;
                    end
                    // move the data frame down if no ack goes ahead of it
                    if (ack_owed_reg && sent)
                        n_res = 2'd2;
                    else if (ack_owed_reg)
                        n_res = 2'd1;
                    else if (sent)
                    begin
                        n_res = 2'd1;
                        res0  = res1;
                    end
                end
                default:
                begin
                    n_res = 2'd0;
                end
            endcase
        end

        res0.link_idle = !awaiting_ack_next && (queue_count_next == '0) && !ack_owed_next;
        res1.link_idle = res0.link_idle;
        res0.last      = (n_res == 2'd1);
        res1.last      = 1'b1;

        rf_wr_next  = rf_wr_reg + RF_AW'(n_res);
        rf_rd_next  = pop_out ? rf_rd_reg + 1'b1 : rf_rd_reg;
        rf_cnt_next = rf_cnt_reg + (RF_AW+1)'(n_res) - (RF_AW+1)'(pop_out);
    end

    // configuration and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_keyed_reg        <= 1'b0;
            timeout_reg           <= sawlc_pkg::TIMEOUT_RST;
            expected_recv_seq_reg <= '0;
            next_send_seq_reg     <= '0;
            ack_owed_reg          <= 1'b0;
            ack_number_reg        <= '0;
            awaiting_ack_reg      <= 1'b0;
            pending_tag_reg       <= '0;
            pending_auth_reg      <= 1'b0;
            last_send_time_reg    <= '0;
            queue_head_reg        <= '0;
            queue_tail_reg        <= '0;
            queue_count_reg       <= '0;
            rf_wr_reg             <= '0;
            rf_rd_reg             <= '0;
            rf_cnt_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sawlc_pkg::REG_LINK_KEYED: link_keyed_reg <= cfg_data[0];
                    sawlc_pkg::REG_TIMEOUT:    timeout_reg    <= cfg_data;
                    default:                   timeout_reg    <= timeout_reg;
                endcase
            end
            expected_recv_seq_reg <= expected_recv_seq_next;
            next_send_seq_reg     <= next_send_seq_next;
            ack_owed_reg          <= ack_owed_next;
            ack_number_reg        <= ack_number_next;
            awaiting_ack_reg      <= awaiting_ack_next;
            pending_tag_reg       <= pending_tag_next;
            pending_auth_reg      <= pending_auth_next;
            last_send_time_reg    <= last_send_time_next;
            queue_head_reg        <= queue_head_next;
            queue_tail_reg        <= queue_tail_next;
            queue_count_reg       <= queue_count_next;
            rf_wr_reg             <= rf_wr_next;
            rf_rd_reg             <= rf_rd_next;
            rf_cnt_reg            <= rf_cnt_next;
        end
    end

    // queue memory; prefetch the entry at the next head, bypass a same-cycle write
    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[queue_tail_reg] <= q_wdata;
        if (q_we && queue_tail_reg == queue_head_next)
            head_data_reg <= q_wdata;
        else
            head_data_reg <= queue_mem[queue_head_next];
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
            rf_mem[rf_wr_reg] <= res0;
        if (n_res == 2'd2)
            rf_mem[rf_wr_reg + 1'b1] <= res1;
    end

    sawlc_pkg::result_t head_res;
    assign head_res = rf_mem[rf_rd_reg];

    assign m_tuser = head_res.result_kind;
    assign m_tlast = head_res.last;
    assign m_tdata = {1'b0,
                      head_res.link_idle,
                      head_res.out_message_tag,
                      head_res.out_authenticated,
                      head_res.out_seq,
                      head_res.out_is_ack,
                      head_res.deliver,
                      head_res.status};

endmodule
